// ===== rtl/core/sfs_pkg.sv =====
// sfs_pkg: shared types and constants of the sprite frame sequencer
// command codes, status codes, default table sizes, stream payload widths and the frame store word
// no dependencies
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int SFS_SLOT_COUNT     = 16;
    localparam int SFS_DEF_COUNT      = 16;
    localparam int SFS_FRAMES_PER_DEF = 16;

    // stream payload widths
    localparam int SFS_IN_DATA_W  = 72;
    localparam int SFS_IN_USER_W  = 3;
    localparam int SFS_OUT_DATA_W = 32;
    localparam int SFS_OUT_USER_W = 2;

    typedef enum logic [2:0] {
        FN_DEFINE  = 3'd0,
        FN_CREATE  = 3'd1,
        FN_DESTROY = 3'd2,
        FN_TICK    = 3'd3,
        FN_QUERY   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] dur;
        logic [7:0]  col;
        logic [7:0]  row;
    } t_frame;

endpackage

// ===== rtl/core/sfs_frame_mem.sv =====
// sfs_frame_mem: frame store holding row, column and duration of every frame
// one write port, one registered read port; uses t_frame from sfs_pkg
`timescale 1ns / 1ps

module sfs_frame_mem import sfs_pkg::*; #(
    parameter int DEPTH = SFS_DEF_COUNT * SFS_FRAMES_PER_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_frame        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_frame        o_rdata
);

    t_frame r_mem [DEPTH];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sfs_tick_unit.sv =====
// sfs_tick_unit: shared time step of one slot, subtract and frame advance
// combinational; the sequencer in the top level feeds it one slot at a time
`timescale 1ns / 1ps

module sfs_tick_unit #(
    parameter int IW = 4,
    parameter int KW = 5
) (
    input  logic [15:0]   i_rem,
    input  logic [15:0]   i_dt,
    input  logic [IW-1:0] i_idx,
    input  logic [KW-1:0] i_cnt,
    input  logic          i_loop,
    output logic          o_expired,
    output logic [15:0]   o_rem,
    output logic [IW-1:0] o_next_idx
);

    logic [16:0] diff;
    logic [31:0] nxt;
    logic        wrap;

    // remaining time is always stored non-negative, so 17 bits hold the difference
    assign diff      = {1'b0, i_rem} - {1'b0, i_dt};
    assign o_expired = diff[16];
    assign o_rem     = diff[15:0];

    always_comb begin
        nxt  = 32'(i_idx) + 32'd1;
        wrap = (nxt >= 32'(i_cnt));
        if (!wrap) begin
            o_next_idx = IW'(nxt);
        end else if (i_loop) begin
            o_next_idx = '0;
        end else begin
            // also covers a count that shrank below the current frame
            o_next_idx = IW'(32'(i_cnt) - 32'd1);
        end
    end

endmodule

// ===== rtl/core/sprite_frame_sequencer.sv =====
// sprite_frame_sequencer: one item at a time; define, destroy and unknown codes go from
// dispatch straight to the finish state, query reads the slot table and then the frame
// store, create scans for the first free slot or the next new one, and tick steps every
// allocated slot, reloading a frame where time runs out; a full output register holds
// the result back; next item is accepted the cycle after it loads. synchronous active-low
// reset clears slot count, active marks and frame counts; frame store and slot table are not
`timescale 1ns / 1ps

module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int SLOT_COUNT     = SFS_SLOT_COUNT,
    parameter int DEF_COUNT      = SFS_DEF_COUNT,
    parameter int FRAMES_PER_DEF = SFS_FRAMES_PER_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // def_id[3:0] frame_index[7:4] frame_row[15:8] frame_column[23:16]
    // frame_duration[39:24] num_frames[44:40] loop_en[45] slot[49:46] dt[65:50]
    input  logic [SFS_IN_DATA_W-1:0]  s_axis_tdata,
    // func[2:0]
    input  logic [SFS_IN_USER_W-1:0]  s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // result_slot[3:0] current_frame[7:4] current_row[15:8] current_column[23:16]
    // active[24]
    output logic [SFS_OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [SFS_OUT_USER_W-1:0] m_axis_tuser
);

    localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int DW     = (DEF_COUNT > 1) ? $clog2(DEF_COUNT) : 1;
    localparam int MAXCNT = (FRAMES_PER_DEF < 31) ? FRAMES_PER_DEF : 31;
    localparam int IW     = (MAXCNT > 1) ? $clog2(MAXCNT) : 1;
    localparam int KW     = $clog2(MAXCNT + 1);
    localparam int FDEPTH = DEF_COUNT * FRAMES_PER_DEF;
    localparam int AW     = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

    typedef struct packed {
        logic [3:0]    def;
        logic          loops;
        logic [IW-1:0] idx;
        logic [15:0]   rem;
    } t_slot_ent;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_TCALC = 9'b000001000,
        S_TLOAD = 9'b000010000,
        S_QFR   = 9'b000100000,
        S_QOUT  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

    function automatic logic [AW-1:0] frame_addr(input logic [3:0] d, input logic [IW-1:0] f);
        frame_addr = AW'(32'(d) * FRAMES_PER_DEF + 32'(f));
    endfunction

    t_state      r_state, n_state;
    logic [CW-1:0] r_idx, n_idx, r_in_use, n_in_use, idx_inc;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [KW-1:0] r_def_cnt [DEF_COUNT];
    logic [KW-1:0] n_def_cnt [DEF_COUNT];
    logic [IW-1:0] r_nidx, n_nidx;
    logic          r_q_ok, n_q_ok;

    // captured item
    logic [2:0]  r_func;
    logic [3:0]  r_def, r_fidx, r_slot_in;
    logic [7:0]  r_row, r_col;
    logic [15:0] r_dur, r_dt;
    logic [4:0]  r_fcnt;
    logic        r_loop;

    // result being built, then output register
    logic [3:0] r_res_slot, n_res_slot, r_res_frame, n_res_frame;
    logic [1:0] r_res_status, n_res_status;
    logic [7:0] r_res_row, n_res_row, r_res_col, n_res_col;
    logic       r_res_act, n_res_act;
    logic       r_out_valid, load_out;
    logic [3:0] r_out_slot, r_out_frame;
    logic [1:0] r_out_status;
    logic [7:0] r_out_row, r_out_col;
    logic       r_out_act;

    // slot table
    t_slot_ent r_slot_mem [SLOT_COUNT];
    t_slot_ent r_slot_rd, slot_wdata;
    logic          slot_we, slot_re;
    logic [SW-1:0] slot_waddr, slot_raddr;

    // frame store port
    logic          fr_we, fr_re;
    logic [AW-1:0] fr_waddr, fr_raddr;
    t_frame        fr_wdata, fr_rdata;

    // shared step unit
    logic          tk_expired;
    logic [15:0]   tk_rem;
    logic [IW-1:0] tk_next;

    logic          create_def_ok, tick_def_ok, slot_ok;
    logic [KW-1:0] create_cnt, tick_cnt;
    logic [SW-1:0] slot_sel;

    sfs_frame_mem #(
        .DEPTH (FDEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    sfs_tick_unit #(
        .IW (IW),
        .KW (KW)
    ) u_tick_unit (
        .i_rem      (r_slot_rd.rem),
        .i_dt       (r_dt),
        .i_idx      (r_slot_rd.idx),
        .i_cnt      (tick_cnt),
        .i_loop     (r_slot_rd.loops),
        .o_expired  (tk_expired),
        .o_rem      (tk_rem),
        .o_next_idx (tk_next)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign idx_inc       = r_idx + CW'(1);
    assign slot_sel      = SW'(32'(r_slot_in));
    assign slot_ok       = (32'(r_slot_in) < 32'(r_in_use));

    always_comb begin
        create_def_ok = (32'(r_def) < DEF_COUNT);
        tick_def_ok   = (32'(r_slot_rd.def) < DEF_COUNT);
        create_cnt    = create_def_ok ? r_def_cnt[DW'(32'(r_def))] : '0;
        tick_cnt      = tick_def_ok ? r_def_cnt[DW'(32'(r_slot_rd.def))] : '0;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_in_use     = r_in_use;
        n_active     = r_active;
        n_def_cnt    = r_def_cnt;
        n_nidx       = r_nidx;
        n_q_ok       = r_q_ok;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        n_res_row    = r_res_row;
        n_res_col    = r_res_col;
        n_res_act    = r_res_act;
        slot_we      = 1'b0;
        slot_waddr   = r_idx[SW-1:0];
        slot_wdata   = r_slot_rd;
        slot_re      = 1'b0;
        slot_raddr   = r_idx[SW-1:0];
        fr_we        = 1'b0;
        fr_waddr     = frame_addr(r_def, IW'(32'(r_fidx)));
        fr_wdata     = '{dur: r_dur, col: r_col, row: r_row};
        fr_re        = 1'b0;
        fr_raddr     = frame_addr(r_slot_rd.def, r_slot_rd.idx);
        load_out     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res_slot   = r_slot_in;
                n_res_status = ST_OK;
                n_res_frame  = '0;
                n_res_row    = '0;
                n_res_col    = '0;
                n_res_act    = 1'b0;
                n_state      = S_FIN;
                case (r_func)
                    FN_DEFINE: begin
                        if (create_def_ok) begin
                            n_def_cnt[DW'(32'(r_def))] = (32'(r_fcnt) > FRAMES_PER_DEF) ?
                                KW'(FRAMES_PER_DEF) : KW'(r_fcnt);
                            fr_we = (32'(r_fidx) < FRAMES_PER_DEF);
                        end else begin
                            n_res_status = ST_UNKNOWN;
                        end
                    end
                    FN_CREATE: begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                    FN_DESTROY: begin
                        if (slot_ok) begin
                            n_active[slot_sel] = 1'b0;
                        end
                    end
                    FN_TICK: begin
                        if (r_in_use != '0) begin
                            n_idx      = '0;
                            slot_re    = 1'b1;
                            slot_raddr = '0;
                            n_state    = S_TCALC;
                        end
                    end
                    FN_QUERY: begin
                        if (slot_ok) begin
                            slot_re    = 1'b1;
                            slot_raddr = slot_sel;
                            n_state    = S_QFR;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCAN: begin
                // the pick is always the scan position: first free slot or the next new one
                if ((r_idx == r_in_use) && (32'(r_in_use) >= SLOT_COUNT)) begin
                    n_res_slot   = '0;
                    n_res_status = ST_FULL;
                    n_state      = S_FIN;
                end else if ((r_idx == r_in_use) || !r_active[r_idx[SW-1:0]]) begin
                    if (r_idx == r_in_use) begin
                        n_in_use = r_in_use + CW'(1);
                    end
                    slot_we                   = 1'b1;
                    slot_wdata                = '{def: r_def, loops: r_loop, idx: '0, rem: '0};
                    n_active[r_idx[SW-1:0]]   = 1'b1;
                    n_res_slot                = 4'(r_idx);
                    n_res_status              = (create_cnt == '0) ? ST_UNKNOWN : ST_OK;
                    n_state                   = S_FIN;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_TCALC: begin
                if (tk_expired && (tick_cnt != '0)) begin
                    fr_re    = 1'b1;
                    fr_raddr = frame_addr(r_slot_rd.def, tk_next);
                    n_nidx   = tk_next;
                    n_state  = S_TLOAD;
                end else begin
                    slot_we        = 1'b1;
                    slot_wdata.rem = tk_expired ? 16'd0 : tk_rem;
                    slot_wdata.idx = tk_expired ? '0 : r_slot_rd.idx;
                    if (idx_inc == r_in_use) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx      = idx_inc;
                        slot_re    = 1'b1;
                        slot_raddr = idx_inc[SW-1:0];
                    end
                end
            end
            S_TLOAD: begin
                slot_we        = 1'b1;
                slot_wdata.idx = r_nidx;
                slot_wdata.rem = fr_rdata.dur;
                if (idx_inc == r_in_use) begin
                    n_state = S_FIN;
                end else begin
                    n_idx      = idx_inc;
                    slot_re    = 1'b1;
                    slot_raddr = idx_inc[SW-1:0];
                    n_state    = S_TCALC;
                end
            end
            S_QFR: begin
                n_res_frame = 4'(r_slot_rd.idx);
                n_res_act   = r_active[slot_sel];
                n_q_ok      = tick_def_ok;
                fr_re       = tick_def_ok;
                n_state     = S_QOUT;
            end
            S_QOUT: begin
                if (r_q_ok) begin
                    n_res_row = fr_rdata.row;
                    n_res_col = fr_rdata.col;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_in_use    <= '0;
            r_active    <= '0;
            r_q_ok      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEF_COUNT; i++) begin
                r_def_cnt[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_in_use  <= n_in_use;
            r_active  <= n_active;
            r_q_ok    <= n_q_ok;
            r_def_cnt <= n_def_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func    <= s_axis_tuser;
            r_def     <= s_axis_tdata[3:0];
            r_fidx    <= s_axis_tdata[7:4];
            r_row     <= s_axis_tdata[15:8];
            r_col     <= s_axis_tdata[23:16];
            r_dur     <= s_axis_tdata[39:24];
            r_fcnt    <= s_axis_tdata[44:40];
            r_loop    <= s_axis_tdata[45];
            r_slot_in <= s_axis_tdata[49:46];
            r_dt      <= s_axis_tdata[65:50];
        end
        r_nidx       <= n_nidx;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_res_row    <= n_res_row;
        r_res_col    <= n_res_col;
        r_res_act    <= n_res_act;
        if (load_out) begin
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
            r_out_frame  <= r_res_frame;
            r_out_row    <= r_res_row;
            r_out_col    <= r_res_col;
            r_out_act    <= r_res_act;
        end
    end

    // slot table memory
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_rd <= r_slot_mem[slot_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_act, r_out_col, r_out_row, r_out_frame, r_out_slot};
    assign m_axis_tuser  = r_out_status;

    a_in_use_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_in_use) <= SLOT_COUNT)
        else $error("slot count beyond table size");

    a_active_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >> r_in_use) == '0)
        else $error("active mark on an unallocated slot");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!slot_we && !fr_we))
        else $error("table write while idle");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule
